// ===== rtl/core/pis_pkg.sv =====
package pis_pkg;

	localparam int CAPACITY  = 8;
	localparam int NUM_TYPES = 8;

	localparam int OP_W     = 2;
	localparam int TYPE_W   = 3;
	localparam int KIND_W   = 3;
	localparam int STATUS_W = 3;
	localparam int MASK_W   = 7;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_STATUS  = 3'd0,
		KIND_PREEMPT = 3'd1,
		KIND_ENTER   = 3'd2,
		KIND_EXIT    = 3'd3,
		KIND_RESUME  = 3'd4
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_FULL      = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_PREEMPT = 2'd0,
		REG_ENTER   = 2'd1,
		REG_EXIT    = 2'd2,
		REG_RESUME  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [MASK_W-1:0] pre;
		logic [MASK_W-1:0] ent;
		logic [MASK_W-1:0] ext;
		logic [MASK_W-1:0] res;
	} pis_masks_t;

	typedef struct packed {
		logic  capture;
		logic  exec;
		logic  load;
		kind_t kind;
	} pis_cmd_t;

	typedef struct packed {
		logic pre;
		logic ent;
		logic ext;
		logic res;
		logic res_en;
	} pis_stat_t;

	// bit t-1 of the mask enables type t; type 0 never reports
	function automatic logic hook_on(logic [MASK_W-1:0] mask, logic [TYPE_W-1:0] t);
		logic [TYPE_W-1:0] idx;
		idx = t - TYPE_W'(1);
		hook_on = (t != '0) && mask[idx];
	endfunction

endpackage

// ===== rtl/core/pis_req_if.sv =====
interface pis_req_if import pis_pkg::*;;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [TYPE_W-1:0] intent_type;

	modport source (output valid, output opcode, output intent_type, input ready);
	modport sink (input valid, input opcode, input intent_type, output ready);
endinterface

// ===== rtl/core/pis_rsp_if.sv =====
interface pis_rsp_if import pis_pkg::*;;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   item_kind;
	logic [TYPE_W-1:0]   event_intent;
	logic [STATUS_W-1:0] status_code;
	logic                present_flag;
	logic [TYPE_W-1:0]   top_intent;
	logic [CNT_W-1:0]    list_depth;
	logic                last_item;

	modport source (output valid, output item_kind, output event_intent, output status_code,
		output present_flag, output top_intent, output list_depth, output last_item,
		input ready);
	modport sink (input valid, input item_kind, input event_intent, input status_code,
		input present_flag, input top_intent, input list_depth, input last_item,
		output ready);
endinterface

// ===== rtl/core/pis_regs.sv =====
module pis_regs import pis_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output pis_masks_t        masks
);

	pis_masks_t masks_q;
	reg_idx_t   idx;
	logic       wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign masks  = masks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masks_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_PREEMPT: masks_q.pre <= pwdata[MASK_W-1:0];
				REG_ENTER:   masks_q.ent <= pwdata[MASK_W-1:0];
				REG_EXIT:    masks_q.ext <= pwdata[MASK_W-1:0];
				REG_RESUME:  masks_q.res <= pwdata[MASK_W-1:0];
				default:     masks_q <= masks_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_PREEMPT: prdata[MASK_W-1:0] = masks_q.pre;
			REG_ENTER:   prdata[MASK_W-1:0] = masks_q.ent;
			REG_EXIT:    prdata[MASK_W-1:0] = masks_q.ext;
			REG_RESUME:  prdata[MASK_W-1:0] = masks_q.res;
			default:     prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/pis_datapath.sv =====
module pis_datapath import pis_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  pis_cmd_t            cmd,
	input  logic [OP_W-1:0]     opcode,
	input  logic [TYPE_W-1:0]   intent_type,
	input  pis_masks_t          masks,
	output pis_stat_t           stat,
	output logic [KIND_W-1:0]   item_kind,
	output logic [TYPE_W-1:0]   event_intent,
	output logic [STATUS_W-1:0] status_code,
	output logic                present_flag,
	output logic [TYPE_W-1:0]   top_intent,
	output logic [CNT_W-1:0]    list_depth,
	output logic                last_item
);

	logic [OP_W-1:0]   op_q;
	logic [TYPE_W-1:0] type_q;
	logic [TYPE_W-1:0] entry_q [CAPACITY];
	logic [CNT_W-1:0]  count_q;
	status_t           status_q;
	logic              present_q;
	logic [TYPE_W-1:0] old_top_q;

	logic [KIND_W-1:0]   kind_q;
	logic [TYPE_W-1:0]   ev_q;
	logic [STATUS_W-1:0] code_q;
	logic                pres_q;
	logic [TYPE_W-1:0]   top_q;
	logic [CNT_W-1:0]    depth_q;
	logic                last_q;

	logic [CAPACITY-1:0] live, match, gt, ge, prev_gt;
	logic [TYPE_W-1:0]   up_e [CAPACITY];
	logic [TYPE_W-1:0]   dn_e [CAPACITY];
	logic [IDX_W-1:0]    top_idx;
	logic [TYPE_W-1:0]   cur_top;
	logic                found, any_gt, full, type_ok;
	logic                do_ins, do_rem;
	status_t             st_code;
	logic                pres;
	logic [TYPE_W-1:0]   ev_sel;

	// parallel compare in every cell
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			live[i]  = CNT_W'(i) < count_q;
			match[i] = live[i] && (entry_q[i] == type_q);
			gt[i]    = live[i] && (entry_q[i] > type_q);
			ge[i]    = live[i] && (entry_q[i] >= type_q);
		end
		up_e[0]    = '0;
		prev_gt[0] = 1'b0;
		for (int i = 1; i < CAPACITY; i++) begin
			up_e[i]    = entry_q[i-1];
			prev_gt[i] = gt[i-1];
		end
		for (int i = 0; i < CAPACITY - 1; i++) begin
			dn_e[i] = entry_q[i+1];
		end
		dn_e[CAPACITY-1] = entry_q[CAPACITY-1];
	end

	assign top_idx = IDX_W'(count_q - CNT_W'(1));
	assign cur_top = (count_q != '0) ? entry_q[top_idx] : '0;
	assign found   = |match;
	assign any_gt  = |gt;
	assign full    = count_q >= CNT_W'(CAPACITY);
	assign type_ok = (type_q != '0) && (32'(type_q) < NUM_TYPES);

	always_comb begin
		do_ins     = 1'b0;
		do_rem     = 1'b0;
		st_code    = ST_OK;
		pres       = 1'b0;
		stat       = '0;
		unique case (op_t'(op_q))
			OP_PUSH: begin
				if (!type_ok) st_code = ST_INVALID;
				else if (found) st_code = ST_OK;
				else if (full) st_code = ST_FULL;
				else begin
					do_ins = 1'b1;
					// no larger entry: the new type becomes the top
					stat.pre = !any_gt && (count_q != '0) && hook_on(masks.pre, cur_top);
					stat.ent = !any_gt && hook_on(masks.ent, type_q);
				end
			end
			OP_POP: begin
				if (!type_ok) st_code = ST_INVALID;
				else if (count_q == '0) st_code = ST_EMPTY;
				else if (!found) st_code = ST_NOT_FOUND;
				else begin
					do_rem   = 1'b1;
					stat.ext = hook_on(masks.ext, type_q);
					stat.res = (cur_top == type_q) && (count_q >= CNT_W'(2));
				end
			end
			OP_QUERY: pres = (type_q != '0) && found;
			default:  st_code = ST_OK;
		endcase
		// after the update the store is stable and cur_top is the new top
		stat.res_en = hook_on(masks.res, cur_top);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= opcode;
			type_q <= intent_type;
		end
		if (cmd.exec) begin
			status_q  <= st_code;
			present_q <= pres;
			old_top_q <= cur_top;
			for (int i = 0; i < CAPACITY; i++) begin
				if (do_ins) begin
					if (prev_gt[i]) entry_q[i] <= up_e[i];
					else if (gt[i] || (CNT_W'(i) == count_q)) entry_q[i] <= type_q;
				end else if (do_rem && ge[i]) begin
					entry_q[i] <= dn_e[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			if (do_ins) count_q <= count_q + CNT_W'(1);
			else if (do_rem) count_q <= count_q - CNT_W'(1);
		end
	end

	always_comb begin
		unique case (cmd.kind)
			KIND_PREEMPT: ev_sel = old_top_q;
			KIND_ENTER:   ev_sel = type_q;
			KIND_EXIT:    ev_sel = type_q;
			KIND_RESUME:  ev_sel = cur_top;
			default:      ev_sel = '0;
		endcase
	end

	// output register, loaded once per result transfer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= cmd.kind;
			ev_q    <= ev_sel;
			code_q  <= (cmd.kind == KIND_STATUS) ? status_q : ST_OK;
			pres_q  <= (cmd.kind == KIND_STATUS) && present_q;
			top_q   <= cur_top;
			depth_q <= count_q;
			last_q  <= cmd.kind == KIND_STATUS;
		end
	end

	assign item_kind    = kind_q;
	assign event_intent = ev_q;
	assign status_code  = code_q;
	assign present_flag = pres_q;
	assign top_intent   = top_q;
	assign list_depth   = depth_q;
	assign last_item    = last_q;

endmodule

// ===== rtl/core/pis_ctrl.sv =====
module pis_ctrl import pis_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	input  pis_stat_t stat,
	output pis_cmd_t  cmd
);

	state_t state_q, state_d;
	logic   pre_q, ent_q, ext_q, res_q;
	logic   out_valid_q;
	logic   can_load;

	assign can_load  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (req_valid) state_d = S_EXEC;
			S_EXEC: state_d = S_EMIT;
			S_EMIT: if (cmd.load && (cmd.kind == KIND_STATUS)) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.kind  = KIND_STATUS;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			S_EXEC: cmd.exec = 1'b1;
			S_EMIT: begin
				cmd.load = can_load;
				priority if (pre_q) cmd.kind = KIND_PREEMPT;
				else if (ent_q) cmd.kind = KIND_ENTER;
				else if (ext_q) cmd.kind = KIND_EXIT;
				else if (res_q && stat.res_en) cmd.kind = KIND_RESUME;
				else cmd.kind = KIND_STATUS;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pre_q       <= 1'b0;
			ent_q       <= 1'b0;
			ext_q       <= 1'b0;
			res_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				pre_q <= stat.pre;
				ent_q <= stat.ent;
				ext_q <= stat.ext;
				res_q <= stat.res;
			end else if (cmd.load) begin
				unique case (cmd.kind)
					KIND_PREEMPT: pre_q <= 1'b0;
					KIND_ENTER:   ent_q <= 1'b0;
					KIND_EXIT:    ext_q <= 1'b0;
					KIND_RESUME:  res_q <= 1'b0;
					default:      res_q <= 1'b0;
				endcase
			end
			if (cmd.load) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/priority_intent_stack_core.sv =====
// channel  dir  handshake      payload
// req      in   valid/ready    opcode, intent_type
// rsp      out  valid/ready    item_kind, event_intent, status_code, present_flag,
//                              top_intent, list_depth, last_item
// apb      in   psel/penable   four 7-bit hook masks at byte addresses 0, 4, 8, 12
//
// one item at a time: a transfer on req, a compare in all eight cells that updates the store
// in the exec step, then one to three results in turn into the output register in the emit
// step, each loaded once the output register is free; the controller sequence sets this order
// req is taken again while the last status result waits in the output register
// a stall on rsp holds the sequencer in its emit step
// arst_n clears the fill count, the masks and the control state; entries need no reset
module priority_intent_stack_core import pis_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	pis_req_if.sink           req,
	pis_rsp_if.source         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	pis_masks_t masks;
	pis_cmd_t   cmd;
	pis_stat_t  stat;

	pis_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.masks   (masks)
	);

	pis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pis_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.opcode       (req.opcode),
		.intent_type  (req.intent_type),
		.masks        (masks),
		.stat         (stat),
		.item_kind    (rsp.item_kind),
		.event_intent (rsp.event_intent),
		.status_code  (rsp.status_code),
		.present_flag (rsp.present_flag),
		.top_intent   (rsp.top_intent),
		.list_depth   (rsp.list_depth),
		.last_item    (rsp.last_item)
	);

endmodule

// ===== rtl/core/pis_checker.sv =====
module pis_checker import pis_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [KIND_W-1:0]   rsp_item_kind,
	input logic [TYPE_W-1:0]   rsp_event_intent,
	input logic [CNT_W-1:0]    rsp_list_depth,
	input logic                rsp_last_item
);

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("input taken while an item is in progress");

	// when idle only the final status result may still wait
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready && rsp_valid |-> rsp_last_item)
		else $error("event result pending while input is open");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before transfer");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_item_kind) && $stable(rsp_event_intent)
			&& $stable(rsp_list_depth) && $stable(rsp_last_item))
		else $error("stalled result changed");

endmodule

bind priority_intent_stack_core pis_checker u_pis_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_item_kind    (rsp.item_kind),
	.rsp_event_intent (rsp.event_intent),
	.rsp_list_depth   (rsp.list_depth),
	.rsp_last_item    (rsp.last_item)
);
